// ===== sv/blmc_pkg.sv =====
package blmc_pkg;

	// Button count and field widths
	localparam int BUTTON_COUNT = 4;
	localparam int BTN_IDX_W    = 2;
	localparam int MODE_W       = 4;
	localparam int TIME_W       = 32;
	localparam logic [BUTTON_COUNT-1:0] BTN_MASK = {BUTTON_COUNT{1'b1}};

	// Action codes
	localparam logic [1:0] ACT_POLL  = 2'd0;
	localparam logic [1:0] ACT_BLINK = 2'd1;
	localparam logic [1:0] ACT_SET   = 2'd2;

	// Button mode codes
	localparam logic [MODE_W-1:0] MODE_OFF         = 4'd0;
	localparam logic [MODE_W-1:0] MODE_ON          = 4'd1;
	localparam logic [MODE_W-1:0] MODE_TOGGLE_ON   = 4'd2;
	localparam logic [MODE_W-1:0] MODE_TOGGLE_DARK = 4'd3;
	localparam logic [MODE_W-1:0] MODE_ON_WHILE    = 4'd4;
	localparam logic [MODE_W-1:0] MODE_OFF_WHILE   = 4'd5;
	localparam logic [MODE_W-1:0] MODE_ON_TILL     = 4'd6;
	localparam logic [MODE_W-1:0] MODE_OFF_TILL    = 4'd7;
	localparam logic [MODE_W-1:0] MODE_FLASHING    = 4'd8;
	localparam logic [MODE_W-1:0] MODE_FLASH_TILL  = 4'd9;

	// Result kinds
	localparam logic KIND_LIGHTS = 1'b0;
	localparam logic KIND_EVENT  = 1'b1;

	typedef struct packed {
		logic [1:0]              action;
		logic [BUTTON_COUNT-1:0] button_status;
		logic [TIME_W-1:0]       time_stamp;
		logic [BTN_IDX_W-1:0]    button_index;
		logic [MODE_W-1:0]       new_mode;
		logic                    new_light;
	} cmd_t;

	typedef struct packed {
		logic                    kind;
		logic [BTN_IDX_W-1:0]    event_button;
		logic                    event_pressed;
		logic [MODE_W-1:0]       event_mode;
		logic [TIME_W-1:0]       event_time;
		logic [BUTTON_COUNT-1:0] lights;
		logic                    last;
	} evt_t;

endpackage

// ===== sv/button_light_mode_controller.sv =====
// Channel | Role   | Handshake              | Payload
// cmd     | input  | cmd_valid / cmd_stall  | cmd_t: action, status, time, set fields
// evt     | output | evt_valid / evt_stall  | evt_t: one light update or button event
//
// A command word is registered, then processed; a new word can be taken every
// cycle while cmd_stall is low. A poll with n changed buttons (up to four)
// loads n event words, sent one per cycle while evt_stall is low; a blink tick
// loads one light update; sets and no-change polls produce nothing, never wait.
// cmd_stall rises only while a word that produces results waits for the buffer.
// Reset (arst_n low) clears pressed bits, lights and phase, and sets every mode
// to the dark toggle mode.
module button_light_mode_controller
	import blmc_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic cmd_valid,
	output logic cmd_stall,
	input  cmd_t cmd,
	output logic evt_valid,
	input  logic evt_stall,
	output evt_t evt
);

	// Input register
	logic valid_s1;
	cmd_t cmd_s1;

	// Block state
	logic [BUTTON_COUNT-1:0] pressed_q;
	logic [BUTTON_COUNT-1:0] lights_q;
	logic                    phase_q;
	logic [MODE_W-1:0]       modes_q [BUTTON_COUNT];

	// Result buffer: one batch of words from a single command
	logic                    bvalid_q;
	logic                    bkind_q;
	logic [BUTTON_COUNT-1:0] bmask_q;
	logic [BUTTON_COUNT-1:0] bstatus_q;
	logic [TIME_W-1:0]       btime_q;
	logic [BUTTON_COUNT-1:0] blights_q;
	logic [MODE_W-1:0]       bmodes_q [BUTTON_COUNT];

	// Next-state logic
	logic [BUTTON_COUNT-1:0] changed;
	logic [BUTTON_COUNT-1:0] nxt_lights;
	logic                    nxt_phase;
	logic [MODE_W-1:0]       nxt_modes [BUTTON_COUNT];
	logic                    has_result;
	logic                    single;
	logic                    batch_free;
	logic                    advance;
	logic [BTN_IDX_W-1:0]    sel;

	// Evaluate the registered command against the current state
	always_comb begin
		changed    = (cmd_s1.button_status ^ pressed_q) & BTN_MASK;
		nxt_lights = lights_q;
		nxt_phase  = phase_q;
		has_result = 1'b0;
		for (int i = 0; i < BUTTON_COUNT; i++) begin
			nxt_modes[i] = modes_q[i];
		end
		unique case (cmd_s1.action)
			ACT_POLL: begin
				has_result = (changed != '0);
				for (int i = 0; i < BUTTON_COUNT; i++) begin
					if (changed[i]) begin
						if (cmd_s1.button_status[i]) begin
							case (modes_q[i])
								MODE_FLASH_TILL: begin
									nxt_modes[i]  = MODE_OFF;
									nxt_lights[i] = 1'b0;
								end
								MODE_ON_TILL: begin
									nxt_modes[i]  = MODE_OFF;
									nxt_lights[i] = ~lights_q[i];
								end
								MODE_OFF_TILL: begin
									nxt_modes[i]  = MODE_ON;
									nxt_lights[i] = ~lights_q[i];
								end
								MODE_TOGGLE_ON: begin
									nxt_modes[i]  = MODE_TOGGLE_DARK;
									nxt_lights[i] = ~lights_q[i];
								end
								MODE_TOGGLE_DARK: begin
									nxt_modes[i]  = MODE_TOGGLE_ON;
									nxt_lights[i] = ~lights_q[i];
								end
								MODE_ON_WHILE, MODE_OFF_WHILE: begin
									nxt_lights[i] = ~lights_q[i];
								end
								default: begin
								end
							endcase
						end else if (modes_q[i] == MODE_ON_WHILE ||
								modes_q[i] == MODE_OFF_WHILE) begin
							nxt_lights[i] = ~lights_q[i];
						end
					end
				end
			end
			ACT_BLINK: begin
				has_result = 1'b1;
				nxt_phase  = ~phase_q;
				for (int i = 0; i < BUTTON_COUNT; i++) begin
					if (modes_q[i] == MODE_FLASHING || modes_q[i] == MODE_FLASH_TILL) begin
						nxt_lights[i] = phase_q;
					end
				end
			end
			ACT_SET: begin
				if ({1'b0, cmd_s1.button_index} < (BTN_IDX_W+1)'(BUTTON_COUNT)) begin
					nxt_modes[cmd_s1.button_index]  = cmd_s1.new_mode;
					nxt_lights[cmd_s1.button_index] = cmd_s1.new_light;
				end
			end
			default: begin
			end
		endcase
	end

	// Handshake control
	assign single     = ((bmask_q & (bmask_q - 1'b1)) == '0);
	assign batch_free = !bvalid_q || (!evt_stall && single);
	assign advance    = valid_s1 && (!has_result || batch_free);
	assign cmd_stall  = valid_s1 && has_result && !batch_free;

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!cmd_stall) begin
			valid_s1 <= cmd_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd_valid && !cmd_stall) begin
			cmd_s1 <= cmd;
		end
	end

	// Commit state when the command leaves the input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pressed_q <= '0;
			lights_q  <= '0;
			phase_q   <= 1'b0;
			for (int i = 0; i < BUTTON_COUNT; i++) begin
				modes_q[i] <= MODE_TOGGLE_DARK;
			end
		end else if (advance) begin
			if (cmd_s1.action == ACT_POLL) begin
				pressed_q <= (pressed_q & ~changed) | (cmd_s1.button_status & changed);
			end
			lights_q <= nxt_lights;
			phase_q  <= nxt_phase;
			for (int i = 0; i < BUTTON_COUNT; i++) begin
				modes_q[i] <= nxt_modes[i];
			end
		end
	end

	// Result buffer control: load a batch, drop each word as it is taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bvalid_q <= 1'b0;
			bmask_q  <= '0;
		end else if (advance && has_result) begin
			bvalid_q <= 1'b1;
			bmask_q  <= (cmd_s1.action == ACT_POLL) ? changed : BUTTON_COUNT'(1);
		end else if (bvalid_q && !evt_stall) begin
			if (single) begin
				bvalid_q <= 1'b0;
			end
			bmask_q <= bmask_q & (bmask_q - 1'b1);
		end
	end

	// Result buffer payload; a blink update carries zero event fields
	always_ff @(posedge clk) begin
		if (advance && has_result) begin
			blights_q <= nxt_lights;
			if (cmd_s1.action == ACT_POLL) begin
				bkind_q   <= KIND_EVENT;
				bstatus_q <= cmd_s1.button_status;
				btime_q   <= cmd_s1.time_stamp;
				for (int i = 0; i < BUTTON_COUNT; i++) begin
					bmodes_q[i] <= nxt_modes[i];
				end
			end else begin
				bkind_q   <= KIND_LIGHTS;
				bstatus_q <= '0;
				btime_q   <= '0;
				for (int i = 0; i < BUTTON_COUNT; i++) begin
					bmodes_q[i] <= '0;
				end
			end
		end
	end

	// Pick the lowest pending button
	always_comb begin
		sel = '0;
		for (int i = BUTTON_COUNT - 1; i >= 0; i--) begin
			if (bmask_q[i]) begin
				sel = BTN_IDX_W'(i);
			end
		end
	end

	// Output word
	assign evt_valid           = bvalid_q;
	assign evt.kind            = bkind_q;
	assign evt.event_button    = sel;
	assign evt.event_pressed   = bstatus_q[sel];
	assign evt.event_mode      = bmodes_q[sel];
	assign evt.event_time      = btime_q;
	assign evt.lights          = blights_q;
	assign evt.last            = single;

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 100ps

module tb
	import blmc_pkg::*;
();

	// Scoreboard: tracks the button state and holds the words the block owes us
	class button_scoreboard;
		logic [BUTTON_COUNT-1:0] held_pressed;
		logic [BUTTON_COUNT-1:0] lit;
		logic                    phase;
		logic [MODE_W-1:0]       mode_of [BUTTON_COUNT];
		evt_t                    expected_evts [$];
		int                      errors;

		function new();
			held_pressed = '0;
			lit = '0;
			phase = 1'b0;
			errors = 0;
			foreach (mode_of[i]) mode_of[i] = MODE_TOGGLE_DARK;
		endfunction

		task report(input string msg);
			$display("ERROR at %0t: %s", $time, msg);
			errors++;
		endtask

		task cmp_field(input string name, input logic [31:0] got, input logic [31:0] want);
			if (got !== want)
				report($sformatf("%s is 0x%0h, should be 0x%0h", name, got, want));
		endtask

		// Advance the button state for one accepted command word
		function void note_cmd(input cmd_t word);
			logic [BUTTON_COUNT-1:0] changed;
			logic [BUTTON_COUNT-1:0] next_lit;
			logic [MODE_W-1:0]       m;
			logic                    flip;
			int                      total;
			int                      n;
			evt_t                    e;

			case (word.action)
				ACT_POLL: begin
					changed = (word.button_status ^ held_pressed) & BTN_MASK;
					if (changed == '0)
						return;
					next_lit = lit;
					total = $countones(changed);
					// step each changed button through its mode machine
					for (int i = 0; i < BUTTON_COUNT; i++) begin
						if (!changed[i])
							continue;
						m = mode_of[i];
						flip = 1'b0;
						if (word.button_status[i]) begin
							case (m)
								MODE_FLASH_TILL: begin
									mode_of[i] = MODE_OFF;
									flip = next_lit[i];
								end
								MODE_ON_TILL: begin
									mode_of[i] = MODE_OFF;
									flip = 1'b1;
								end
								MODE_OFF_TILL: begin
									mode_of[i] = MODE_ON;
									flip = 1'b1;
								end
								MODE_TOGGLE_ON: begin
									mode_of[i] = MODE_TOGGLE_DARK;
									flip = 1'b1;
								end
								MODE_TOGGLE_DARK: begin
									mode_of[i] = MODE_TOGGLE_ON;
									flip = 1'b1;
								end
								MODE_ON_WHILE, MODE_OFF_WHILE: flip = 1'b1;
								default: flip = 1'b0;
							endcase
						end else if (m == MODE_ON_WHILE || m == MODE_OFF_WHILE) begin
							flip = 1'b1;
						end
						if (flip)
							next_lit[i] = ~next_lit[i];
					end
					lit = next_lit;
					// one event per changed button, lowest index first
					n = 0;
					for (int i = 0; i < BUTTON_COUNT; i++) begin
						if (!changed[i])
							continue;
						e = '0;
						e.kind = KIND_EVENT;
						e.event_button = BTN_IDX_W'(i);
						e.event_pressed = word.button_status[i];
						e.event_mode = mode_of[i];
						e.event_time = word.time_stamp;
						e.lights = lit;
						e.last = (n + 1 == total);
						expected_evts.push_back(e);
						n++;
					end
					held_pressed = word.button_status & BTN_MASK;
				end
				ACT_BLINK: begin
					phase = ~phase;
					foreach (mode_of[i])
						if (mode_of[i] == MODE_FLASHING || mode_of[i] == MODE_FLASH_TILL)
							lit[i] = ~phase;
					e = '0;
					e.kind = KIND_LIGHTS;
					e.lights = lit;
					e.last = 1'b1;
					expected_evts.push_back(e);
				end
				ACT_SET: begin
					if (word.button_index < BUTTON_COUNT) begin
						mode_of[word.button_index] = word.new_mode;
						lit[word.button_index] = word.new_light;
					end
				end
				default: ;
			endcase
		endfunction

		// Compare one accepted result word with the oldest expectation
		task check_evt(input evt_t got);
			evt_t want;

			if (expected_evts.size() == 0) begin
				report($sformatf("unexpected result word 0x%0h", got));
				return;
			end
			want = expected_evts.pop_front();
			cmp_field("kind", 32'(got.kind), 32'(want.kind));
			cmp_field("event_button", 32'(got.event_button), 32'(want.event_button));
			cmp_field("event_pressed", 32'(got.event_pressed), 32'(want.event_pressed));
			cmp_field("event_mode", 32'(got.event_mode), 32'(want.event_mode));
			cmp_field("event_time", got.event_time, want.event_time);
			cmp_field("lights", 32'(got.lights), 32'(want.lights));
			cmp_field("last", 32'(got.last), 32'(want.last));
		endtask
	endclass

	localparam logic [1:0] ACT_UNUSED = 2'd3;
	localparam int         ITEM_COUNT = 170;
	localparam int         STALL_PCT = 18;
	localparam int         IDLE_LIMIT = 2000;
	localparam int         TAIL_CYCLES = 20;

	logic clk;
	logic arst_n;
	logic cmd_valid;
	logic cmd_stall;
	cmd_t cmd;
	logic evt_valid;
	logic evt_stall;
	evt_t evt;

	logic quiet;
	int   idle_cycles;
	int   n_sent;
	cmd_t word;

	button_scoreboard sb = new();

	button_light_mode_controller u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd_valid(cmd_valid),
		.cmd_stall(cmd_stall),
		.cmd      (cmd),
		.evt_valid(evt_valid),
		.evt_stall(evt_stall),
		.evt      (evt)
	);

	initial begin
		clk = 1'b0;
		arst_n = 1'b0;
		cmd_valid = 1'b0;
		cmd = '0;
		evt_stall = 1'b0;
		quiet = 1'b0;
		idle_cycles = 0;
	end

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Stall the result channel at random, except in the quiet stretch
	always @(negedge clk) begin
		evt_stall <= !quiet && ($urandom_range(0, 99) < STALL_PCT);
	end

	// Check result words and watch for a hang
	always @(posedge clk) begin
		if (arst_n) begin
			if (evt_valid && !evt_stall)
				sb.check_evt(evt);
			if ((cmd_valid && !cmd_stall) || (evt_valid && !evt_stall)) begin
				idle_cycles <= 0;
			end else if (idle_cycles >= IDLE_LIMIT) begin
				$display("Mismatches found");
				$finish;
			end else begin
				idle_cycles <= idle_cycles + 1;
			end
		end
	end

	function automatic cmd_t noise_word();
		cmd_t w;

		w.action = 2'($urandom_range(0, 3));
		w.button_status = 4'($urandom_range(0, 15));
		w.time_stamp = $urandom;
		w.button_index = 2'($urandom_range(0, 3));
		w.new_mode = ($urandom_range(0, 99) < 85) ? 4'($urandom_range(0, 9))
				: 4'($urandom_range(10, 15));
		w.new_light = 1'($urandom_range(0, 1));
		return w;
	endfunction

	// Offer one command word and hold it until taken
	task automatic send_cmd(input cmd_t w);
		while (!quiet && $urandom_range(0, 99) < STALL_PCT) begin
			cmd_valid <= 1'b0;
			cmd <= noise_word();
			@(negedge clk);
		end
		cmd_valid <= 1'b1;
		cmd <= w;
		do @(posedge clk); while (cmd_stall);
		sb.note_cmd(w);
		@(negedge clk);
	endtask

	task automatic send_fields(input logic [1:0] act, input logic [3:0] status,
			input logic [31:0] stamp, input logic [1:0] idx, input logic [3:0] mode,
			input logic light);
		cmd_t w;

		w.action = act;
		w.button_status = status;
		w.time_stamp = stamp;
		w.button_index = idx;
		w.new_mode = mode;
		w.new_light = light;
		send_cmd(w);
	endtask

	// Hold off the sender until every owed result word has come
	task automatic wait_for_drain();
		cmd_valid <= 1'b0;
		@(negedge clk);
		while (sb.expected_evts.size() != 0) @(negedge clk);
	endtask

	initial begin
		repeat (11) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// poll with no change, then all four toggle buttons pressed and released
		send_fields(ACT_POLL, 4'h0, 32'h0000_0000, 2'd3, 4'hF, 1'b1);
		send_fields(ACT_POLL, 4'hF, 32'hFFFF_FFFF, 2'd0, 4'h0, 1'b0);
		send_fields(ACT_POLL, 4'h0, 32'h0000_0000, 2'd3, 4'hF, 1'b1);
		// while and till modes
		send_fields(ACT_SET, 4'hF, 32'h1234_5678, 2'd0, MODE_ON_WHILE, 1'b0);
		send_fields(ACT_SET, 4'h0, 32'h0, 2'd1, MODE_OFF_WHILE, 1'b1);
		send_fields(ACT_SET, 4'h0, 32'h0, 2'd2, MODE_ON_TILL, 1'b0);
		send_fields(ACT_SET, 4'h0, 32'h0, 2'd3, MODE_OFF_TILL, 1'b1);
		send_fields(ACT_POLL, 4'hF, 32'h5A5A_5A5A, 2'd0, 4'h0, 1'b0);
		send_fields(ACT_POLL, 4'h0, 32'hA5A5_A5A5, 2'd0, 4'h0, 1'b0);
		// flashing modes under blink ticks, then pressed
		send_fields(ACT_SET, 4'h0, 32'h0, 2'd0, MODE_FLASHING, 1'b0);
		send_fields(ACT_SET, 4'h0, 32'h0, 2'd1, MODE_FLASH_TILL, 1'b1);
		send_fields(ACT_SET, 4'h0, 32'h0, 2'd2, MODE_OFF, 1'b1);
		send_fields(ACT_SET, 4'h0, 32'h0, 2'd3, MODE_ON, 1'b0);
		send_fields(ACT_BLINK, 4'hF, 32'hFFFF_FFFF, 2'd3, 4'hF, 1'b1);
		send_fields(ACT_BLINK, 4'h0, 32'h0, 2'd0, 4'h0, 1'b0);
		send_fields(ACT_POLL, 4'hF, 32'h8000_0001, 2'd0, 4'h0, 1'b0);
		send_fields(ACT_POLL, 4'h0, 32'h7FFF_FFFE, 2'd0, 4'h0, 1'b0);
		// mode codes past the last one never react
		send_fields(ACT_SET, 4'h0, 32'h0, 2'd0, 4'd15, 1'b1);
		send_fields(ACT_SET, 4'h0, 32'h0, 2'd1, 4'd10, 1'b0);
		send_fields(ACT_BLINK, 4'h0, 32'h0, 2'd0, 4'h0, 1'b0);
		send_fields(ACT_POLL, 4'h3, 32'hDEAD_BEEF, 2'd0, 4'h0, 1'b0);
		// unused action is dropped
		send_fields(ACT_UNUSED, 4'hC, 32'hFFFF_FFFF, 2'd2, 4'h9, 1'b1);
		send_fields(ACT_SET, 4'h0, 32'h0, 2'd2, MODE_TOGGLE_ON, 1'b0);
		send_fields(ACT_POLL, 4'hC, 32'h0F0F_0F0F, 2'd0, 4'h0, 1'b0);
		send_fields(ACT_POLL, 4'h0, 32'hF0F0_F0F0, 2'd0, 4'h0, 1'b0);

		wait_for_drain();

		// random words: polls, mostly single-button presses and releases, amid sets and ticks
		n_sent = 0;
		while (n_sent < ITEM_COUNT) begin
			quiet <= (n_sent >= 70 && n_sent < 120);
			word = noise_word();
			case ($urandom_range(0, 99)) inside
				[0:44]: begin
					word.action = ACT_POLL;
					if ($urandom_range(0, 99) < 70)
						word.button_status = sb.held_pressed ^
								(4'b1 << $urandom_range(0, BUTTON_COUNT - 1));
				end
				[45:59]: word.action = ACT_BLINK;
				[60:94]: word.action = ACT_SET;
				default: word.action = ACT_UNUSED;
			endcase
			send_cmd(word);
			if (word.action != ACT_UNUSED)
				n_sent++;
			if (n_sent == 140 && word.action != ACT_UNUSED)
				wait_for_drain();
		end

		wait_for_drain();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (sb.expected_evts.size() != 0)
			sb.report($sformatf("%0d result words never came", sb.expected_evts.size()));
		if (sb.errors == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule

// ===== files.f =====
sv/blmc_pkg.sv
sv/button_light_mode_controller.sv
tb/tb.sv
